/* src/euclidean_distance_stream_top_assert.svh */
// Assertion macros shared by the distance stream RTL.
`ifndef EUCLIDEAN_DISTANCE_STREAM_TOP_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_STREAM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define EDS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define EDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/eds_pkg.sv */
// Package with widths, defaults and queue types of the distance stream.
`timescale 1ns / 1ps
package eds_pkg;

  localparam int unsigned MAX_DIM_DEF = 1024;
  localparam int unsigned COORD_W_DEF = 16;

  localparam int unsigned LEN_W  = 11;
  localparam int unsigned SUM_W  = 42;
  localparam int unsigned ROOT_W = 21;

  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_ADDR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_LVL_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } eds_push_t;

  typedef struct packed {
    logic               valid;
    logic [SUM_W-1:0]   sum;
    logic [Q_LVL_W-1:0] level;
  } eds_head_t;

endpackage

/* src/eds_if.sv */
// Stream interfaces for the coordinate pairs and the distances.
`timescale 1ns / 1ps
interface eds_in_if #(
  parameter int unsigned CoordW = eds_pkg::COORD_W_DEF
);
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] p_coord;
  logic signed [CoordW-1:0] q_coord;

  modport source (output valid, output p_coord, output q_coord, input ready);
  modport sink (input valid, input p_coord, input q_coord, output ready);
endinterface

interface eds_out_if;
  logic                        valid;
  logic                        ready;
  logic [eds_pkg::ROOT_W-1:0]  distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

/* src/eds_fifo.sv */
// Short queue of finished square sums between the front and the root unit.
`timescale 1ns / 1ps
module eds_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eds_pkg::eds_push_t push_i,
  input  logic               pop_i,
  output eds_pkg::eds_head_t head_o
);
  import eds_pkg::*;

  logic [SUM_W-1:0]    mem_q [Q_DEPTH];
  logic [Q_ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_LVL_W-1:0]  level_q, level_d;

  function automatic logic [Q_ADDR_W-1:0] ptr_next(input logic [Q_ADDR_W-1:0] ptr);
    logic [Q_ADDR_W-1:0] nxt;
    if (ptr == Q_ADDR_W'(Q_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  always_comb begin
    wr_ptr_d = push_i.valid ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    level_d  = level_q + Q_LVL_W'(push_i.valid) - Q_LVL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.sum;
    end
  end

  assign head_o.valid = (level_q != '0);
  assign head_o.sum   = mem_q[rd_ptr_q];
  assign head_o.level = level_q;

endmodule

/* src/eds_front.sv */
// Front end: takes coordinate pairs, squares the differences and sums each vector.
`timescale 1ns / 1ps
module eds_front #(
  parameter int unsigned MAX_DIM     = eds_pkg::MAX_DIM_DEF,
  parameter int unsigned COORD_WIDTH = eds_pkg::COORD_W_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [eds_pkg::LEN_W-1:0] cfg_wdata_i,
  eds_in_if.sink                    in_i,
  input  logic [eds_pkg::Q_LVL_W-1:0] q_level_i,
  output eds_pkg::eds_push_t        push_o
);
  import eds_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIM + 1);
  localparam int unsigned CmpW = (CntW > LEN_W) ? CntW : LEN_W;

  logic [LEN_W-1:0] len_q;
  logic [CmpW-1:0]  len_eff;

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic            accept, last;

  logic signed [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH:0]        mag;

  logic                   s1_valid_q, s1_last_q;
  logic [COORD_WIDTH-1:0] s1_mag_q;
  logic [2*COORD_WIDTH-1:0] prod;
  logic                   s2_valid_q, s2_last_q;
  logic [SUM_W-1:0]       s2_sq_q;

  logic [SUM_W-1:0] sum_q, sum_d, sum_new;
  logic [Q_LVL_W:0] credit;

  // A zero length acts as one, a length above the maximum saturates.
  always_comb begin
    if (len_q == '0) begin
      len_eff = CmpW'(1);
    end else if (CmpW'(len_q) > CmpW'(MAX_DIM)) begin
      len_eff = CmpW'(MAX_DIM);
    end else begin
      len_eff = CmpW'(len_q);
    end
  end

  // Queue slots are reserved for every vector end still in the pipeline,
  // so a finished sum always finds room.
  assign credit = {1'b0, q_level_i}
                + (Q_LVL_W + 1)'(s1_valid_q & s1_last_q)
                + (Q_LVL_W + 1)'(s2_valid_q & s2_last_q);
  assign in_i.ready = (credit < (Q_LVL_W + 1)'(Q_DEPTH));
  assign accept = in_i.valid & in_i.ready;

  assign cnt_inc = cnt_q + 1'b1;
  assign last    = (CmpW'(cnt_inc) >= len_eff);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last ? '0 : cnt_inc;
    end
  end

  assign diff = $signed({in_i.p_coord[COORD_WIDTH-1], in_i.p_coord})
              - $signed({in_i.q_coord[COORD_WIDTH-1], in_i.q_coord});
  assign mag  = diff[COORD_WIDTH] ? -diff : diff;

  assign prod = s1_mag_q * s1_mag_q;

  assign sum_new = sum_q + s2_sq_q;

  always_comb begin
    sum_d = sum_q;
    if (s2_valid_q) begin
      sum_d = s2_last_q ? '0 : sum_new;
    end
  end

  assign push_o.valid = s2_valid_q & s2_last_q;
  assign push_o.sum   = sum_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= LEN_W'(1);
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      sum_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      cnt_q      <= cnt_d;
      s1_valid_q <= accept;
      s1_last_q  <= accept & last;
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
      sum_q      <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mag_q <= mag[COORD_WIDTH-1:0];
    s2_sq_q  <= SUM_W'(prod);
  end

endmodule

/* src/eds_sqrt.sv */
// Back end: bit-serial integer square root of each queued sum, with output register.
`timescale 1ns / 1ps
module eds_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eds_pkg::eds_head_t head_i,
  output logic               pop_o,
  eds_out_if.source          out_o
);
  import eds_pkg::*;

  localparam int unsigned RemW  = ROOT_W + 2;
  localparam int unsigned StepW = $clog2(ROOT_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [SUM_W-1:0]  rad_q, rad_d;
  logic [RemW-1:0]   rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              fits;
  logic              out_valid_q, out_valid_d;
  logic [ROOT_W-1:0] dist_q, dist_d;
  logic              out_free;

  // One result bit per cycle: bring down two radicand bits and try 4r+1.
  assign rem_sh = {rem_q[RemW-3:0], rad_q[SUM_W-1:SUM_W-2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    dist_d      = dist_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          rad_d   = head_i.sum;
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        rad_d  = {rad_q[SUM_W-3:0], 2'b00};
        rem_d  = fits ? (rem_sh - trial) : rem_sh;
        root_d = {root_q[ROOT_W-2:0], fits};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(ROOT_W - 1)) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          dist_d      = root_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    dist_q <= dist_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.distance = dist_q;

endmodule

/* src/euclidean_distance_stream_top.sv */
// Path: the last pair of a vector passes registers s1 and s2, its sum is queued, and the
// bit-serial root unit works it out and registers the distance. Throughput: one pair per
// cycle while the four-entry sum queue has room; the root unit takes no new sum until it
// has handed out the last. Reset: rst_ni is asynchronous, active low; it empties the
// pipeline and queue, clears the sum and element count, and sets the length len_q to 1.
`timescale 1ns / 1ps
`include "euclidean_distance_stream_top_assert.svh"
module euclidean_distance_stream_top #(
  parameter int unsigned MAX_DIM     = eds_pkg::MAX_DIM_DEF,
  parameter int unsigned COORD_WIDTH = eds_pkg::COORD_W_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [eds_pkg::LEN_W-1:0] cfg_wdata_i,
  eds_in_if.sink                    in_i,
  eds_out_if.source                 out_o
);
  import eds_pkg::*;

  eds_push_t push;
  eds_head_t head;
  logic      pop;

  eds_front #(
    .MAX_DIM     (MAX_DIM),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_level_i   (head.level),
    .push_o      (push)
  );

  eds_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head)
  );

  eds_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  `EDS_ASSERT_IMPLIES(a_no_push_full, push.valid, head.level < Q_LVL_W'(Q_DEPTH), "sum pushed into a full queue")
  `EDS_ASSERT_IMPLIES(a_no_pop_empty, pop, head.valid, "root unit popped an empty queue")
  `EDS_ASSERT_IMPLIES(a_ready_room, in_i.ready, head.level < Q_LVL_W'(Q_DEPTH), "ready raised with a full queue")
  `EDS_ASSERT_NEXT(a_last_pop, pop && (head.level == Q_LVL_W'(1)) && !push.valid, !head.valid, "queue not empty after popping its only word")

endmodule
